// File: sv/sis_pkg.sv
// Shared types, codes and widths of the script instruction sequencer.
`timescale 1ns / 1ps

package sis_pkg;

    localparam int CMD_W      = 2;
    localparam int OP_W       = 4;
    localparam int WORD_W     = 32;
    localparam int START_W    = 16;
    localparam int PC_OUT_W   = 16;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 56;

    localparam int ADDR_BITS_DEF   = 16;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int FLAG_COUNT_DEF  = 1024;

    localparam logic [CMD_W-1:0] CMD_EXEC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHOICE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
    localparam logic [OP_W-1:0] OP_SETF   = 4'd1;
    localparam logic [OP_W-1:0] OP_CLRF   = 4'd2;
    localparam logic [OP_W-1:0] OP_TESTF  = 4'd3;
    localparam logic [OP_W-1:0] OP_TEXT   = 4'd4;
    localparam logic [OP_W-1:0] OP_ADB    = 4'd5;
    localparam logic [OP_W-1:0] OP_XFN    = 4'd6;
    localparam logic [OP_W-1:0] OP_JMP    = 4'd7;
    localparam logic [OP_W-1:0] OP_BRA    = 4'd8;
    localparam logic [OP_W-1:0] OP_EQ     = 4'd9;
    localparam logic [OP_W-1:0] OP_NEQ    = 4'd10;
    localparam logic [OP_W-1:0] OP_CHOOSE = 4'd11;
    localparam logic [OP_W-1:0] OP_CALL   = 4'd12;
    localparam logic [OP_W-1:0] OP_RET    = 4'd13;

    localparam logic [KIND_W-1:0] EV_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] EV_TEXT   = 3'd1;
    localparam logic [KIND_W-1:0] EV_ADB    = 3'd2;
    localparam logic [KIND_W-1:0] EV_XFN    = 3'd3;
    localparam logic [KIND_W-1:0] EV_CHOOSE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_OP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [OP_W-1:0]    op;
        logic [WORD_W-1:0]  immediate;
        logic [WORD_W-1:0]  choice_value;
        logic [START_W-1:0] start_address;
    } sis_item_t;

    typedef struct packed {
        logic [PC_OUT_W-1:0] next_pc;
        logic                test_bit;
        logic                asleep;
        logic                stopped;
        logic [KIND_W-1:0]   event_kind;
        logic [WORD_W-1:0]   event_string;
        logic [STATUS_W-1:0] status;
    } sis_result_t;

    typedef struct packed {
        logic we;
        logic data;
    } sis_flag_wr_t;

endpackage

// File: sv/sis_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module sis_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// File: sv/sis_exec.sv
// Execute stage: architectural state, return stack and instruction decode.
`timescale 1ns / 1ps

module sis_exec #(
    parameter int ADDR_BITS   = sis_pkg::ADDR_BITS_DEF,
    parameter int STACK_DEPTH = sis_pkg::STACK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  sis_pkg::sis_item_t   item,
    input  logic                 flag_bit,
    output sis_pkg::sis_result_t result,
    output sis_pkg::sis_flag_wr_t flag_wr
);

    import sis_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [ADDR_BITS-1:0] pc_reg, pc_next, pc_inc, target;
    logic                 cond_reg, cond_next;
    logic [WORD_W-1:0]    chosen_reg, chosen_next;
    logic                 sleep_reg, sleep_next;
    logic                 halt_reg, halt_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next, depth_m1;
    logic                 push;
    logic [ADDR_BITS-1:0] stack_reg [STACK_DEPTH];
    logic [KIND_W-1:0]    kind;
    logic [WORD_W-1:0]    str;
    logic [STATUS_W-1:0]  status;

    assign pc_inc   = pc_reg + 1'b1;
    assign target   = ADDR_BITS'(item.immediate);
    assign depth_m1 = depth_reg - 1'b1;

    always_comb
    begin
        pc_next      = pc_reg;
        cond_next    = cond_reg;
        chosen_next  = chosen_reg;
        sleep_next   = sleep_reg;
        halt_next    = halt_reg;
        depth_next   = depth_reg;
        push         = 1'b0;
        kind         = EV_NONE;
        str          = '0;
        status       = ST_OK;
        flag_wr.we   = 1'b0;
        flag_wr.data = 1'b0;
        priority if (item.command == CMD_CHOICE)
        begin
            chosen_next = item.choice_value;
            sleep_next  = 1'b0;
        end
        else if (item.command == CMD_RESTART)
        begin
            pc_next    = ADDR_BITS'(item.start_address);
            sleep_next = 1'b0;
            halt_next  = 1'b0;
            depth_next = '0;
        end
        else if (item.command != CMD_EXEC || sleep_reg || halt_reg)
        begin
            status = ST_IGNORED;
        end
        else
        begin
            pc_next = pc_inc;
            unique case (item.op)
                OP_NOP: ;
                OP_SETF:
                begin
                    flag_wr.we   = 1'b1;
                    flag_wr.data = 1'b1;
                end
                OP_CLRF:   flag_wr.we = 1'b1;
                OP_TESTF:  cond_next = flag_bit;
                OP_TEXT:
                begin
                    kind = EV_TEXT;
                    str  = item.immediate;
                end
                OP_ADB:
                begin
                    kind = EV_ADB;
                    str  = item.immediate;
                end
                OP_XFN:
                begin
                    kind = EV_XFN;
                    str  = item.immediate;
                end
                OP_JMP:    pc_next = target;
                OP_BRA:
                begin
                    if (cond_reg)
                    begin
                        pc_next = target;
                    end
                end
                OP_EQ:     cond_next = (chosen_reg == item.immediate);
                OP_NEQ:    cond_next = (chosen_reg != item.immediate);
                OP_CHOOSE:
                begin
                    sleep_next = 1'b1;
                    kind       = EV_CHOOSE;
                end
                OP_CALL:
                begin
                    if (depth_reg == DEPTH_W'(STACK_DEPTH))
                    begin
                        halt_next = 1'b1;
                        status    = ST_OVERFLOW;
                    end
                    else
                    begin
                        push       = 1'b1;
                        depth_next = depth_reg + 1'b1;
                        pc_next    = target;
                    end
                end
                OP_RET:
                begin
                    if (depth_reg != '0)
                    begin
                        depth_next = depth_m1;
                        pc_next    = stack_reg[depth_m1[SIDX_W-1:0]];
                    end
                    else
                    begin
                        halt_next = 1'b1;
                    end
                end
                default:   status = ST_BAD_OP;
            endcase
        end
    end

    assign result.next_pc      = PC_OUT_W'(pc_next);
    assign result.test_bit     = cond_next;
    assign result.asleep       = sleep_next;
    assign result.stopped      = halt_next;
    assign result.event_kind   = kind;
    assign result.event_string = str;
    assign result.status       = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            cond_reg   <= 1'b0;
            chosen_reg <= '0;
            sleep_reg  <= 1'b0;
            halt_reg   <= 1'b1;
            depth_reg  <= '0;
        end
        else if (en)
        begin
            pc_reg     <= pc_next;
            cond_reg   <= cond_next;
            chosen_reg <= chosen_next;
            sleep_reg  <= sleep_next;
            halt_reg   <= halt_next;
            depth_reg  <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && push)
        begin
            stack_reg[depth_reg[SIDX_W-1:0]] <= pc_inc;
        end
    end

endmodule

// File: sv/script_instruction_sequencer_top.sv
// Top level of the script instruction sequencer: input pipeline, flag RAM, output register.
//
// channel | direction | handshake         | payload
// s_*     | in        | s_tvalid/s_tready | s_tdata: op, immediate, choice_value, start_address
//         |           |                   | s_tuser: command
// m_*     | out       | m_tvalid/m_tready | m_tdata: next_pc .. status; m_tuser: event_kind
//
// One transfer per cycle while the output is not stalled and the flag clear is done;
// a result passes the input register, flag index reduction, flag RAM read and result register.
// After reset the flag RAM is cleared one entry per cycle, with s_tready low until all
// FLAG_COUNT entries are cleared.
// A stalled m_tready stalls the whole pipeline; s_tready follows it.
`timescale 1ns / 1ps

module script_instruction_sequencer_top #(
    parameter int ADDR_BITS   = sis_pkg::ADDR_BITS_DEF,
    parameter int STACK_DEPTH = sis_pkg::STACK_DEPTH_DEF,
    parameter int FLAG_COUNT  = sis_pkg::FLAG_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op[3:0], immediate[35:4], choice_value[67:36], start_address[83:68], zero[87:84]
    input  logic [sis_pkg::S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [sis_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc[15:0], test_bit[16], asleep[17], stopped[18], event_string[50:19],
    // status[52:51], zero[55:53]
    output logic [sis_pkg::M_TDATA_W-1:0] m_tdata,
    // event_kind[2:0]
    output logic [sis_pkg::KIND_W-1:0]    m_tuser
);

    import sis_pkg::*;

    localparam int FIDX_W = $clog2(FLAG_COUNT);
    localparam int PROD_W = 2 * WORD_W + 1;
    localparam logic [PROD_W-1:0] RECIP_M =
        ((PROD_W'(1) << (WORD_W + FIDX_W)) + PROD_W'(FLAG_COUNT) - PROD_W'(1))
        / PROD_W'(FLAG_COUNT);

    logic              adv;
    logic              clearing_reg;
    logic [FIDX_W-1:0] clr_cnt_reg;

    logic              s0_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    sis_item_t         in_item, s0_item_reg, s1_item_reg, s2_item_reg;
    logic [PROD_W-1:0] prod;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W-1:0] s1_rem;
    logic [FIDX_W-1:0] s1_fidx, s2_fidx_reg;

    logic              fwd_hit_reg, fwd_hit_next, fwd_data_reg;
    logic              ram_we, ram_wdata, ram_rdata;
    logic [FIDX_W-1:0] ram_waddr;
    logic              flag_bit;
    logic              exec_en;
    sis_result_t       exec_result, out_reg;
    sis_flag_wr_t      flag_wr;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && !clearing_reg;
    assign exec_en  = adv && s2_valid_reg;

    assign in_item.command       = s_tuser;
    assign in_item.op            = s_tdata[3:0];
    assign in_item.immediate     = s_tdata[35:4];
    assign in_item.choice_value  = s_tdata[67:36];
    assign in_item.start_address = s_tdata[83:68];

    // immediate modulo FLAG_COUNT by reciprocal multiplication
    assign prod    = PROD_W'(s0_item_reg.immediate) * RECIP_M;
    assign s1_rem  = s1_item_reg.immediate - WORD_W'(q_reg * WORD_W'(FLAG_COUNT));
    assign s1_fidx = s1_rem[FIDX_W-1:0];

    assign ram_we    = clearing_reg || (exec_en && flag_wr.we);
    assign ram_waddr = clearing_reg ? clr_cnt_reg : s2_fidx_reg;
    assign ram_wdata = !clearing_reg && flag_wr.data;

    assign fwd_hit_next = exec_en && flag_wr.we && (s2_fidx_reg == s1_fidx);
    assign flag_bit     = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    sis_ram #(
        .WIDTH (1),
        .DEPTH (FLAG_COUNT)
    ) u_flag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (adv),
        .raddr (s1_fidx),
        .rdata (ram_rdata)
    );

    sis_exec #(
        .ADDR_BITS   (ADDR_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (exec_en),
        .item     (s2_item_reg),
        .flag_bit (flag_bit),
        .result   (exec_result),
        .flag_wr  (flag_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == FIDX_W'(FLAG_COUNT - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                s0_valid_reg  <= s_tvalid && s_tready;
                s1_valid_reg  <= s0_valid_reg;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
                fwd_hit_reg   <= s1_valid_reg && fwd_hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg  <= in_item;
            s1_item_reg  <= s0_item_reg;
            q_reg        <= WORD_W'(prod >> (WORD_W + FIDX_W));
            s2_item_reg  <= s1_item_reg;
            s2_fidx_reg  <= s1_fidx;
            fwd_data_reg <= flag_wr.data;
            out_reg      <= exec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {3'b000, out_reg.status, out_reg.event_string, out_reg.stopped,
                       out_reg.asleep, out_reg.test_bit, out_reg.next_pc};

    a_ignored_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.status == ST_IGNORED |-> m_tuser == EV_NONE)
        else $error("ignored step produced an event");

    a_choose_sleeps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_CHOOSE |-> out_reg.asleep)
        else $error("choosing request without sleep");

    a_overflow_halts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.status == ST_OVERFLOW |-> out_reg.stopped)
        else $error("stack overflow did not halt");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s0_valid_reg && !m_tvalid)
        else $error("item in flight during flag clear");

endmodule

// File: bench/sis_result_checker.sv
// Result checker: predicts each sequencer step from the input transfers and compares outputs.
`timescale 1ns / 1ps

module sis_result_checker
    import sis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [KIND_W-1:0]     m_tuser,
    output int                    errors,
    output int                    pending
);

    logic [ADDR_BITS_DEF-1:0] shadow_pc;
    logic                     shadow_cond;
    logic [WORD_W-1:0]        shadow_chosen;
    logic                     shadow_sleeping;
    logic                     shadow_halted;
    logic [ADDR_BITS_DEF-1:0] shadow_stack [STACK_DEPTH_DEF];
    int                       shadow_depth;
    logic                     shadow_flags [FLAG_COUNT_DEF];

    sis_result_t expected_results [$];

    task automatic step_sequencer(input sis_item_t it, output sis_result_t r);
        int fidx;
        fidx = it.immediate % FLAG_COUNT_DEF;
        r = '0;
        r.status = ST_OK;
        r.event_kind = EV_NONE;
        if (it.command == CMD_CHOICE) begin
            shadow_chosen = it.choice_value;
            shadow_sleeping = 1'b0;
        end else if (it.command == CMD_RESTART) begin
            shadow_pc = it.start_address[ADDR_BITS_DEF-1:0];
            shadow_sleeping = 1'b0;
            shadow_halted = 1'b0;
            shadow_depth = 0;
        end else if (it.command != CMD_EXEC || shadow_sleeping || shadow_halted) begin
            r.status = ST_IGNORED;
        end else begin
            shadow_pc = shadow_pc + 1'b1;
            case (it.op)
                OP_NOP: ;
                OP_SETF: shadow_flags[fidx] = 1'b1;
                OP_CLRF: shadow_flags[fidx] = 1'b0;
                OP_TESTF: shadow_cond = shadow_flags[fidx];
                OP_TEXT:
                begin
                    r.event_kind = EV_TEXT;
                    r.event_string = it.immediate;
                end
                OP_ADB:
                begin
                    r.event_kind = EV_ADB;
                    r.event_string = it.immediate;
                end
                OP_XFN:
                begin
                    r.event_kind = EV_XFN;
                    r.event_string = it.immediate;
                end
                OP_JMP: shadow_pc = it.immediate[ADDR_BITS_DEF-1:0];
                OP_BRA:
                begin
                    if (shadow_cond)
                        shadow_pc = it.immediate[ADDR_BITS_DEF-1:0];
                end
                OP_EQ: shadow_cond = (shadow_chosen == it.immediate);
                OP_NEQ: shadow_cond = (shadow_chosen != it.immediate);
                OP_CHOOSE:
                begin
                    shadow_sleeping = 1'b1;
                    r.event_kind = EV_CHOOSE;
                end
                OP_CALL:
                begin
                    if (shadow_depth >= STACK_DEPTH_DEF) begin
                        shadow_halted = 1'b1;
                        r.status = ST_OVERFLOW;
                    end else begin
                        shadow_stack[shadow_depth] = shadow_pc;
                        shadow_depth++;
                        shadow_pc = it.immediate[ADDR_BITS_DEF-1:0];
                    end
                end
                OP_RET:
                begin
                    if (shadow_depth > 0) begin
                        shadow_depth--;
                        shadow_pc = shadow_stack[shadow_depth];
                    end else begin
                        shadow_halted = 1'b1;
                    end
                end
                default: r.status = ST_BAD_OP;
            endcase
        end
        r.next_pc = shadow_pc[PC_OUT_W-1:0];
        r.test_bit = shadow_cond;
        r.asleep = shadow_sleeping;
        r.stopped = shadow_halted;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sis_item_t   item;
        sis_result_t want;
        sis_result_t got;
        if (!rst_n) begin
            shadow_pc = '0;
            shadow_cond = 1'b0;
            shadow_chosen = '0;
            shadow_sleeping = 1'b0;
            shadow_halted = 1'b1;
            shadow_depth = 0;
            for (int i = 0; i < FLAG_COUNT_DEF; i++)
                shadow_flags[i] = 1'b0;
            for (int i = 0; i < STACK_DEPTH_DEF; i++)
                shadow_stack[i] = '0;
            expected_results.delete();
            errors = 0;
            pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.next_pc = m_tdata[15:0];
                got.test_bit = m_tdata[16];
                got.asleep = m_tdata[17];
                got.stopped = m_tdata[18];
                got.event_string = m_tdata[50:19];
                got.status = m_tdata[52:51];
                got.event_kind = m_tuser;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result pc=%h tb=%b sl=%b st=%b kind=%0d str=%h sts=%0d",
                             $time, got.next_pc, got.test_bit, got.asleep, got.stopped,
                             got.event_kind, got.event_string, got.status);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch expected pc=%h tb=%b sl=%b st=%b kind=%0d str=%h sts=%0d",
                                 $time, want.next_pc, want.test_bit, want.asleep, want.stopped,
                                 want.event_kind, want.event_string, want.status);
                        $display("%0t:          actual pc=%h tb=%b sl=%b st=%b kind=%0d str=%h sts=%0d",
                                 $time, got.next_pc, got.test_bit, got.asleep, got.stopped,
                                 got.event_kind, got.event_string, got.status);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                item.command = s_tuser;
                item.op = s_tdata[3:0];
                item.immediate = s_tdata[35:4];
                item.choice_value = s_tdata[67:36];
                item.start_address = s_tdata[83:68];
                step_sequencer(item, want);
                expected_results.push_back(want);
            end
            pending = expected_results.size();
        end
    end

endmodule

// File: bench/tb_top.sv
// Testbench top: drives script steps through the sequencer and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
    import sis_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam logic [OP_W-1:0]  OP_UNDEF_LO = 4'd14;
    localparam logic [OP_W-1:0]  OP_UNDEF_HI = 4'd15;
    localparam int               HOLD_CYCLES = 120;
    localparam int               DRAIN_CYCLES = 20;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    int                   errors;
    int                   pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int steps_sent = 0;
    logic [WORD_W-1:0] last_choice = '0;
    bit after_choose = 1'b0;

    script_instruction_sequencer_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sis_result_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hold off the result channel for a long stretch when asked, else stall at random
    always @(negedge clk)
    begin
        if (holds_done != holds_asked)
        begin
            holds_done = holds_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_step(input logic [CMD_W-1:0] cmd, input logic [OP_W-1:0] op,
                             input logic [WORD_W-1:0] imm, input logic [WORD_W-1:0] chv,
                             input logic [START_W-1:0] start);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, start, chv, imm, op};
        if (cmd == CMD_CHOICE)
            last_choice = chv;
        after_choose = (cmd == CMD_EXEC && op == OP_CHOOSE);
        steps_sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic exec_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] imm);
        send_step(CMD_EXEC, op, imm, $urandom, START_W'($urandom));
    endtask

    task automatic call_burst();
        int depth_goal;
        int returns;
        depth_goal = $urandom_range(14, 18);
        returns = $urandom_range(0, 18);
        send_step(CMD_RESTART, OP_W'($urandom), $urandom, $urandom, START_W'($urandom));
        repeat (depth_goal)
            exec_op(OP_CALL, $urandom);
        repeat (returns)
            exec_op(OP_RET, $urandom);
    endtask

    task automatic random_step();
        int pick;
        int op_pick;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] imm;
        pick = $urandom_range(0, 99);
        op_pick = $urandom_range(0, 99);
        imm = $urandom;
        // crowd the flag indexes so set, clear and test meet each other
        if ($urandom_range(0, 1))
            imm[9:0] = 10'($urandom_range(0, 15));
        if (after_choose && pick < 75)
        begin
            send_step(CMD_CHOICE, OP_W'($urandom), $urandom, $urandom, START_W'($urandom));
        end
        else if (pick < 2)
        begin
            call_burst();
        end
        else if (pick < 7)
        begin
            send_step(CMD_RESTART, OP_W'($urandom), $urandom, $urandom, START_W'($urandom));
        end
        else if (pick < 13)
        begin
            send_step(CMD_CHOICE, OP_W'($urandom), $urandom, $urandom, START_W'($urandom));
        end
        else if (pick < 15)
        begin
            send_step(CMD_UNUSED, OP_W'($urandom), $urandom, $urandom, START_W'($urandom));
        end
        else
        begin
            if (op_pick < 10)
                op = OP_CALL;
            else if (op_pick < 16)
                op = OP_RET;
            else if (op_pick < 20)
                op = $urandom_range(0, 1) ? OP_UNDEF_LO : OP_UNDEF_HI;
            else
                op = OP_W'($urandom_range(OP_NOP, OP_CHOOSE));
            if ((op == OP_EQ || op == OP_NEQ) && $urandom_range(0, 1))
                imm = last_choice;
            exec_op(op, imm);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                             input bit long_hold);
        int goal;
        goal = steps_sent + count;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (steps_sent < goal)
        begin
            if (long_hold && holds_asked == 0 && steps_sent >= goal - count / 2)
                holds_asked++;
            random_step();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        exec_op(OP_NOP, '0);
        send_step(CMD_UNUSED, OP_NOP, '0, '0, '0);
        send_step(CMD_RESTART, OP_UNDEF_HI, '1, '1, '1);
        exec_op(OP_NOP, '0);
        exec_op(OP_SETF, '1);
        exec_op(OP_TESTF, 32'h0000_03FF);
        exec_op(OP_BRA, '1);
        exec_op(OP_CLRF, '1);
        exec_op(OP_TESTF, '1);
        exec_op(OP_BRA, 32'h0000_1234);
        exec_op(OP_TEXT, '1);
        exec_op(OP_ADB, '0);
        exec_op(OP_XFN, 32'hA5A5_5A5A);
        exec_op(OP_JMP, 32'h1234_0010);
        send_step(CMD_CHOICE, OP_NOP, '0, '1, '0);
        exec_op(OP_EQ, '1);
        exec_op(OP_NEQ, '0);
        exec_op(OP_CHOOSE, '0);
        exec_op(OP_NOP, '0);
        send_step(CMD_CHOICE, OP_NOP, '1, '0, '1);
        exec_op(OP_CALL, 32'h0000_0100);
        exec_op(OP_RET, '0);
        exec_op(OP_UNDEF_LO, '0);
        exec_op(OP_UNDEF_HI, '1);
        exec_op(OP_RET, '0);

        run_phase(0, 0, 200, 1'b1);
        run_phase(71, 0, 190, 1'b0);
        run_phase(0, 71, 190, 1'b0);
        run_phase(37, 37, 190, 1'b0);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
